// ===== hw/rtl/lfp_pkg.sv =====
// Shared types, constants and helper functions of the LED frame parser.
`timescale 1ns / 1ps

package lfp_pkg;

	localparam int MAGIC_LEN = 3;
	localparam int HEADER_LEN = 6;
	localparam int BYTES_PER_PIXEL = 3;
	localparam int CNT_W = 16;
	localparam int LEN_W = 18;
	localparam int IDX_W = 11;
	localparam int PIX_W = 10;
	localparam logic [PIX_W-1:0] PIX_SAT = 10'h3FF;
	localparam logic [7:0] GAP_TIMEOUT_RESET = 8'd2;
	localparam logic [7:0] CHECK_SALT_RESET = 8'h55;

	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_CONSUME = 1'b1;

	typedef enum logic [3:0] {
		ST_MAGIC_OK = 4'd0,
		ST_MAGIC_BAD = 4'd1,
		ST_COUNT = 4'd2,
		ST_CHECK_OK = 4'd3,
		ST_CHECK_BAD = 4'd4,
		ST_DATA = 4'd5,
		ST_FRAME_DONE = 4'd6,
		ST_BUSY_IGNORED = 4'd7,
		ST_TOO_LONG = 4'd8,
		ST_CONSUMED = 4'd9
	} status_t;

	typedef struct packed {
		logic [7:0] gap_timeout_ms;
		logic [7:0] check_salt;
	} cfg_t;

	typedef struct packed {
		logic func;
		logic [7:0] rx_byte;
		logic [31:0] now_ms;
	} item_t;

	typedef struct packed {
		status_t status;
		logic [IDX_W-1:0] byte_index;
		logic [7:0] byte_value;
		logic store_valid;
		logic frame_done;
		logic [PIX_W-1:0] pixel_count;
		logic [PIX_W-1:0] peak_pixels;
	} res_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] pos);
		logic [7:0] b;
		case (pos)
			2'd0: b = 8'h41;
			2'd1: b = 8'h64;
			2'd2: b = 8'h61;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [PIX_W-1:0] sat_pixels(input logic [CNT_W-1:0] v);
		return (v > CNT_W'(PIX_SAT)) ? PIX_SAT : v[PIX_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/lfp_if.sv =====
// Valid/ready channel interfaces for incoming bytes and parse results.
`timescale 1ns / 1ps

interface lfp_in_if import lfp_pkg::*; ();
	logic valid;
	logic ready;
	logic func;
	logic [7:0] rx_byte;
	logic [31:0] now_ms;

	modport source (output valid, func, rx_byte, now_ms, input ready);
	modport sink (input valid, func, rx_byte, now_ms, output ready);
endinterface

interface lfp_out_if import lfp_pkg::*; ();
	logic valid;
	logic ready;
	status_t status;
	logic [IDX_W-1:0] byte_index;
	logic [7:0] byte_value;
	logic store_valid;
	logic frame_done;
	logic [PIX_W-1:0] pixel_count;
	logic [PIX_W-1:0] peak_pixels;

	modport source (output valid, status, byte_index, byte_value, store_valid, frame_done,
		pixel_count, peak_pixels, input ready);
	modport sink (input valid, status, byte_index, byte_value, store_valid, frame_done,
		pixel_count, peak_pixels, output ready);
endinterface

// ===== hw/rtl/led_frame_parser.sv =====
// Top level of the LED frame parser: input register, parser, result register, APB registers.
//
//  channel | direction | handshake        | word
//  --------+-----------+------------------+---------------------------------------------
//  rx      | in        | valid / ready    | func, rx_byte, now_ms
//  res     | out       | valid / ready    | status, index, value, flags, pixel counts
//  apb     | in        | psel/penable     | gap_timeout_ms at 0x0, check_salt at 0x4
//
// One word is accepted per cycle while the result side is not stalled.
// The parse step is one pass of logic between the input and result registers,
// and the parser state is updated as a word moves from one to the other.
// When the result is stalled the input register still takes one more word.
// Reset is asynchronous and clears the frame state, the peak count and the registers.
`timescale 1ns / 1ps

module led_frame_parser import lfp_pkg::*; #(
	parameter int MAX_PIXELS = 512
) (
	input logic clk,
	input logic arst_n,
	lfp_in_if.sink rx,
	lfp_out_if.source res,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	cfg_t cfg;
	item_t in_item;
	item_t item_s1;
	logic valid_s1;
	logic valid_s2;
	logic out_free;
	logic advance;
	res_t res_d;
	res_t res_s2;

	assign in_item.func = rx.func;
	assign in_item.rx_byte = rx.rx_byte;
	assign in_item.now_ms = rx.now_ms;
	assign advance = valid_s1 && out_free;

	lfp_apb_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	lfp_in_stage u_in (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(rx.valid),
		.in_item(in_item),
		.advance(advance),
		.in_ready(rx.ready),
		.valid_s1(valid_s1),
		.item_s1(item_s1)
	);

	lfp_parse_core #(.MAX_PIXELS(MAX_PIXELS)) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.fire(advance),
		.item(item_s1),
		.res_d(res_d)
	);

	lfp_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(advance),
		.res_d(res_d),
		.out_ready(res.ready),
		.out_free(out_free),
		.valid_s2(valid_s2),
		.res_s2(res_s2)
	);

	assign res.valid = valid_s2;
	assign res.status = res_s2.status;
	assign res.byte_index = res_s2.byte_index;
	assign res.byte_value = res_s2.byte_value;
	assign res.store_valid = res_s2.store_valid;
	assign res.frame_done = res_s2.frame_done;
	assign res.pixel_count = res_s2.pixel_count;
	assign res.peak_pixels = res_s2.peak_pixels;

endmodule

// ===== hw/rtl/lfp_apb_regs.sv =====
// APB configuration registers: gap timeout and header check salt.
`timescale 1ns / 1ps

module lfp_apb_regs import lfp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output cfg_t cfg
);

	localparam logic REG_GAP_TIMEOUT = 1'b0;
	localparam logic REG_CHECK_SALT = 1'b1;

	logic [7:0] gap_q;
	logic [7:0] salt_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= GAP_TIMEOUT_RESET;
			salt_q <= CHECK_SALT_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_GAP_TIMEOUT: gap_q <= pwdata[7:0];
				REG_CHECK_SALT: salt_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_GAP_TIMEOUT: prdata = {24'b0, gap_q};
			REG_CHECK_SALT: prdata = {24'b0, salt_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.gap_timeout_ms = gap_q;
	assign cfg.check_salt = salt_q;

endmodule

// ===== hw/rtl/lfp_in_stage.sv =====
// Input register that holds one accepted word until the parser takes it.
`timescale 1ns / 1ps

module lfp_in_stage import lfp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input item_t in_item,
	input logic advance,
	output logic in_ready,
	output logic valid_s1,
	output item_t item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== hw/rtl/lfp_parse_core.sv =====
// Frame parser state and the single-pass logic that turns one word into its result.
`timescale 1ns / 1ps

module lfp_parse_core import lfp_pkg::*; #(
	parameter int MAX_PIXELS = 512
) (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic fire,
	input item_t item,
	output res_t res_d
);

	localparam int POS_MAX = BYTES_PER_PIXEL * MAX_PIXELS + HEADER_LEN - 1;
	localparam int POS_W = $clog2(POS_MAX + 2);

	logic [POS_W-1:0] pos_q, pos_d, pos_eff, pos_inc;
	logic [31:0] last_q, last_d, gap;
	logic [7:0] hi_q, hi_d, lo_q, lo_d;
	logic busy_q, busy_d;
	logic [PIX_W-1:0] peak_q, peak_d, sat_cnt;
	logic [CNT_W-1:0] cnt_q;
	logic [LEN_W-1:0] frame_len;
	logic [7:0] chk;
	logic finish;

	assign cnt_q = {hi_q, lo_q};
	assign sat_cnt = sat_pixels(cnt_q);
	assign gap = item.now_ms - last_q;
	assign pos_eff = (pos_q != '0 && gap > {24'b0, cfg.gap_timeout_ms}) ? '0 : pos_q;
	assign pos_inc = pos_eff + POS_W'(1);
	assign frame_len = LEN_W'(cnt_q) * LEN_W'(BYTES_PER_PIXEL) + LEN_W'(HEADER_LEN);
	assign chk = hi_q ^ lo_q ^ cfg.check_salt;

	always_comb begin
		pos_d = pos_q;
		last_d = last_q;
		hi_d = hi_q;
		lo_d = lo_q;
		busy_d = busy_q;
		peak_d = peak_q;
		finish = 1'b0;
		res_d.status = ST_MAGIC_OK;
		res_d.byte_index = '0;
		res_d.byte_value = '0;
		res_d.store_valid = 1'b0;
		res_d.frame_done = 1'b0;

		if (item.func == FUNC_CONSUME) begin
			res_d.status = ST_CONSUMED;
			if (busy_q) begin
				busy_d = 1'b0;
				pos_d = '0;
				last_d = item.now_ms;
			end
		end else if (busy_q) begin
			res_d.status = ST_BUSY_IGNORED;
		end else begin
			last_d = item.now_ms;
			if (pos_eff < POS_W'(MAGIC_LEN)) begin
				res_d.byte_index = IDX_W'(pos_eff);
				if (item.rx_byte == magic_byte(pos_eff[1:0])) begin
					res_d.status = ST_MAGIC_OK;
					pos_d = pos_inc;
				end else begin
					res_d.status = ST_MAGIC_BAD;
					pos_d = '0;
				end
			end else if (pos_eff == POS_W'(MAGIC_LEN)) begin
				hi_d = item.rx_byte;
				res_d.status = ST_COUNT;
				pos_d = pos_inc;
			end else if (pos_eff == POS_W'(MAGIC_LEN + 1)) begin
				lo_d = item.rx_byte;
				res_d.status = ST_COUNT;
				pos_d = pos_inc;
			end else if (pos_eff == POS_W'(HEADER_LEN - 1)) begin
				if (item.rx_byte != chk) begin
					res_d.status = ST_CHECK_BAD;
					pos_d = '0;
				end else if (cnt_q > CNT_W'(MAX_PIXELS)) begin
					res_d.status = ST_TOO_LONG;
					pos_d = '0;
				end else if (cnt_q == '0) begin
					res_d.status = ST_FRAME_DONE;
					finish = 1'b1;
				end else begin
					res_d.status = ST_CHECK_OK;
					pos_d = POS_W'(HEADER_LEN);
				end
			end else begin
				res_d.byte_index = IDX_W'(pos_eff - POS_W'(HEADER_LEN));
				res_d.byte_value = item.rx_byte;
				res_d.store_valid = 1'b1;
				pos_d = pos_inc;
				if (LEN_W'(pos_inc) >= frame_len) begin
					res_d.status = ST_FRAME_DONE;
					finish = 1'b1;
				end else begin
					res_d.status = ST_DATA;
				end
			end
		end

		if (finish) begin
			res_d.frame_done = 1'b1;
			busy_d = 1'b1;
			pos_d = '0;
			if (sat_cnt > peak_q) begin
				peak_d = sat_cnt;
			end
		end

		res_d.pixel_count = sat_pixels({hi_d, lo_d});
		res_d.peak_pixels = peak_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			last_q <= '0;
			hi_q <= '0;
			lo_q <= '0;
			busy_q <= 1'b0;
			peak_q <= '0;
		end else if (fire) begin
			pos_q <= pos_d;
			last_q <= last_d;
			hi_q <= hi_d;
			lo_q <= lo_d;
			busy_q <= busy_d;
			peak_q <= peak_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_busy_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pos_q == '0)
		else $error("parser busy with a partial frame position");
	a_peak_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= $past(peak_q))
		else $error("peak pixel count went down");
	a_done_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_d.frame_done |=> busy_q)
		else $error("completed frame did not make the parser busy");
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(POS_MAX))
		else $error("frame position beyond the longest frame");
`endif

endmodule

// ===== hw/rtl/lfp_out_stage.sv =====
// Result register that presents one result word until the consumer takes it.
`timescale 1ns / 1ps

module lfp_out_stage import lfp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic load,
	input res_t res_d,
	input logic out_ready,
	output logic out_free,
	output logic valid_s2,
	output res_t res_s2
);

	assign out_free = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res_d;
		end
	end

endmodule

// ===== tb/lfp_tb_pkg.sv =====
// Register addresses, the frame size limit and the sync bytes shared by the testbench files.
`timescale 1ns / 1ps

package lfp_tb_pkg;

	localparam logic [2:0] REG_GAP_TIMEOUT = 3'h0;
	localparam logic [2:0] REG_CHECK_SALT = 3'h4;
	localparam int TB_MAX_PIXELS = 512;

	// The three leading bytes of a frame, 'A', 'd' and 'a'.
	function automatic logic [7:0] sync_byte(input int pos);
		logic [7:0] b;
		case (pos)
			0: b = 8'h41;
			1: b = 8'h64;
			default: b = 8'h61;
		endcase
		return b;
	endfunction

endpackage

// ===== tb/led_frame_parser_checker.sv =====
// Checker of the LED frame parser: predicts each result word and compares it with the block.
`timescale 1ns / 1ps

module led_frame_parser_checker import lfp_pkg::*; import lfp_tb_pkg::*; #(
	parameter int MAX_PIXELS = 512
) (
	input logic clk,
	input logic arst_n,
	lfp_in_if rx,
	lfp_out_if res,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic pready,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output int fails,
	output int pending
);

	logic [7:0] gap_limit;
	logic [7:0] salt;
	logic [IDX_W-1:0] pos;
	logic [31:0] last_ms;
	logic [7:0] cnt_hi;
	logic [7:0] cnt_lo;
	logic busy;
	logic [PIX_W-1:0] peak;
	res_t expected_q[$];
	res_t got;
	res_t want;
	int mismatches;

	function automatic logic [PIX_W-1:0] clamp_pixels(input logic [15:0] v);
		return (v > 16'd1023) ? '1 : v[PIX_W-1:0];
	endfunction

	function automatic void close_frame();
		logic [PIX_W-1:0] c;
		c = clamp_pixels({cnt_hi, cnt_lo});
		if (c > peak) begin
			peak = c;
		end
		busy = 1'b1;
		pos = '0;
	endfunction

	function automatic res_t parse_word(input logic f, input logic [7:0] b,
		input logic [31:0] now);
		res_t r;
		logic [15:0] cnt;
		r = '0;
		r.status = ST_CONSUMED;
		if (f == FUNC_CONSUME) begin
			if (busy) begin
				busy = 1'b0;
				pos = '0;
				last_ms = now;
			end
		end else if (busy) begin
			r.status = ST_BUSY_IGNORED;
		end else begin
			if (pos != 0 && (now - last_ms) > 32'(gap_limit)) begin
				pos = '0;
			end
			last_ms = now;
			cnt = {cnt_hi, cnt_lo};
			if (pos < MAGIC_LEN) begin
				r.byte_index = pos;
				if (b != sync_byte(int'(pos))) begin
					r.status = ST_MAGIC_BAD;
					pos = '0;
				end else begin
					r.status = ST_MAGIC_OK;
					pos = pos + 1'b1;
				end
			end else if (pos == MAGIC_LEN) begin
				cnt_hi = b;
				r.status = ST_COUNT;
				pos = pos + 1'b1;
			end else if (pos == MAGIC_LEN + 1) begin
				cnt_lo = b;
				r.status = ST_COUNT;
				pos = pos + 1'b1;
			end else if (pos == MAGIC_LEN + 2) begin
				if (b != (cnt_hi ^ cnt_lo ^ salt)) begin
					r.status = ST_CHECK_BAD;
					pos = '0;
				end else if (int'(cnt) > MAX_PIXELS) begin
					r.status = ST_TOO_LONG;
					pos = '0;
				end else if (cnt == 0) begin
					r.status = ST_FRAME_DONE;
					r.frame_done = 1'b1;
					close_frame();
				end else begin
					r.status = ST_CHECK_OK;
					pos = IDX_W'(HEADER_LEN);
				end
			end else begin
				r.byte_index = pos - IDX_W'(HEADER_LEN);
				r.byte_value = b;
				r.store_valid = 1'b1;
				pos = pos + 1'b1;
				if (int'(pos) >= int'(cnt) * BYTES_PER_PIXEL + HEADER_LEN) begin
					r.status = ST_FRAME_DONE;
					r.frame_done = 1'b1;
					close_frame();
				end else begin
					r.status = ST_DATA;
				end
			end
		end
		r.pixel_count = clamp_pixels({cnt_hi, cnt_lo});
		r.peak_pixels = peak;
		return r;
	endfunction

	task automatic report(input string field, input int seen, input int wanted);
		if (mismatches < 100) begin
			$display("%0t ns: %s mismatch, got %0d, expected %0d", $time, field, seen, wanted);
		end
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit = GAP_TIMEOUT_RESET;
			salt = CHECK_SALT_RESET;
			pos = '0;
			last_ms = '0;
			cnt_hi = '0;
			cnt_lo = '0;
			busy = 1'b0;
			peak = '0;
			expected_q.delete();
			pending <= 0;
			fails <= mismatches;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					REG_GAP_TIMEOUT: gap_limit = pwdata[7:0];
					REG_CHECK_SALT: salt = pwdata[7:0];
					default: ;
				endcase
			end
			if (rx.valid && rx.ready) begin
				expected_q.push_back(parse_word(rx.func, rx.rx_byte, rx.now_ms));
			end
			if (res.valid && res.ready) begin
				got.status = res.status;
				got.byte_index = res.byte_index;
				got.byte_value = res.byte_value;
				got.store_valid = res.store_valid;
				got.frame_done = res.frame_done;
				got.pixel_count = res.pixel_count;
				got.peak_pixels = res.peak_pixels;
				if (expected_q.size() == 0) begin
					report("unrequested word status", int'(got.status), -1);
				end else begin
					want = expected_q.pop_front();
					if (got.status !== want.status)
						report("status", int'(got.status), int'(want.status));
					if (got.byte_index !== want.byte_index)
						report("byte_index", int'(got.byte_index), int'(want.byte_index));
					if (got.byte_value !== want.byte_value)
						report("byte_value", int'(got.byte_value), int'(want.byte_value));
					if (got.store_valid !== want.store_valid)
						report("store_valid", int'(got.store_valid), int'(want.store_valid));
					if (got.frame_done !== want.frame_done)
						report("frame_done", int'(got.frame_done), int'(want.frame_done));
					if (got.pixel_count !== want.pixel_count)
						report("pixel_count", int'(got.pixel_count), int'(want.pixel_count));
					if (got.peak_pixels !== want.peak_pixels)
						report("peak_pixels", int'(got.peak_pixels), int'(want.peak_pixels));
				end
			end
			pending <= expected_q.size();
			fails <= mismatches;
		end
	end

endmodule

// ===== tb/led_frame_parser_tb.sv =====
// Top of the LED frame parser testbench: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 1ps

module led_frame_parser_tb;
	import lfp_pkg::*;
	import lfp_tb_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	int fails;
	int pending;
	int cycles;
	int sent;
	int stall_left;
	bit calm;
	bit steady;
	bit force_jump;
	logic [7:0] gap_cfg;
	logic [7:0] salt_cfg;
	logic [31:0] now;

	lfp_in_if rx();
	lfp_out_if res();

	led_frame_parser #(.MAX_PIXELS(TB_MAX_PIXELS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	led_frame_parser_checker #(.MAX_PIXELS(TB_MAX_PIXELS)) chk (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.fails(fails),
		.pending(pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("led_frame_parser_tb: FAIL");
			$finish;
		end
	end

	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(1, 3);
		end else if (r < 92) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			res.ready <= 1'b0;
			stall_left--;
		end else begin
			res.ready <= 1'b1;
			if (!calm && $urandom_range(0, 9) == 0) begin
				stall_left = pause_len();
			end
		end
	end

	task automatic send(input logic f, input logic [7:0] b);
		int g;
		rx.valid <= 1'b1;
		rx.func <= f;
		rx.rx_byte <= b;
		rx.now_ms <= now;
		@(posedge clk);
		while (!rx.ready) @(posedge clk);
		sent++;
		g = (calm || $urandom_range(0, 99) < 65) ? 0 : pause_len();
		if (g > 0) begin
			rx.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic send_at(input logic f, input logic [7:0] b, input int step);
		now += 32'(step);
		send(f, b);
	endtask

	task automatic send_byte(input logic [7:0] b);
		int r;
		r = $urandom_range(0, 999);
		if (force_jump || (!steady && r < 10)) begin
			now += 32'(gap_cfg) + 32'd1;
			if ($urandom_range(0, 1) == 1) begin
				now += 32'($urandom_range(0, 3000));
			end
			force_jump = 1'b0;
		end else if (!steady && r < 15) begin
			now = $urandom;
		end else begin
			now += 32'($urandom_range(0, gap_cfg));
		end
		send(FUNC_BYTE, b);
	endtask

	task automatic header(input logic [7:0] hi, input logic [7:0] lo, input logic [7:0] chk_b);
		for (int i = 0; i < MAGIC_LEN; i++) begin
			send_at(FUNC_BYTE, sync_byte(i), 1);
		end
		send_at(FUNC_BYTE, hi, 1);
		send_at(FUNC_BYTE, lo, 1);
		send_at(FUNC_BYTE, chk_b, 1);
	endtask

	task automatic send_frame(input int npix, input bit bad_check, input int cut);
		logic [7:0] frame_q[$];
		logic [7:0] hi;
		logic [7:0] lo;
		logic [7:0] chk_b;
		bit whole;
		hi = 8'(npix >> 8);
		lo = 8'(npix);
		chk_b = hi ^ lo ^ salt_cfg;
		if (bad_check) begin
			chk_b ^= 8'(1 << $urandom_range(0, 7));
		end
		for (int i = 0; i < MAGIC_LEN; i++) begin
			frame_q.push_back(sync_byte(i));
		end
		frame_q.push_back(hi);
		frame_q.push_back(lo);
		frame_q.push_back(chk_b);
		whole = !bad_check && npix <= TB_MAX_PIXELS;
		if (whole) begin
			for (int i = 0; i < npix * BYTES_PER_PIXEL; i++) begin
				frame_q.push_back(8'($urandom));
			end
		end
		if (cut > 0 && cut < frame_q.size()) begin
			frame_q = frame_q[0:cut-1];
			whole = 1'b0;
			force_jump = 1'b1;
		end
		foreach (frame_q[i]) begin
			send_byte(frame_q[i]);
		end
		if (whole) begin
			repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
			send_at(FUNC_CONSUME, 8'($urandom), $urandom_range(0, 3));
			if ($urandom_range(0, 9) == 0) begin
				send_at(FUNC_CONSUME, 8'($urandom), 1);
			end
		end
	endtask

	task automatic wait_drained();
		rx.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (5) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] gap, input logic [7:0] salt);
		wait_drained();
		apb_write(REG_GAP_TIMEOUT, 32'(gap));
		apb_write(REG_CHECK_SALT, 32'(salt));
		gap_cfg = gap;
		salt_cfg = salt;
	endtask

	task automatic run_phase(input int n);
		int stop;
		int r;
		int p;
		int npix;
		stop = sent + n;
		while (sent < stop) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				p = $urandom_range(0, 99);
				if (p < 10) begin
					npix = 0;
				end else if (p < 70) begin
					npix = $urandom_range(1, 4);
				end else if (p < 85) begin
					npix = $urandom_range(5, 40);
				end else if (p < 95) begin
					npix = $urandom_range(TB_MAX_PIXELS + 1, 65535);
				end else begin
					npix = $urandom_range(41, 100);
				end
				send_frame(npix, $urandom_range(0, 99) < 5,
					($urandom_range(0, 99) < 8) ? $urandom_range(1, 8) : 0);
			end else if (r < 90) begin
				repeat ($urandom_range(1, 8)) begin
					if ($urandom_range(0, 9) == 0) begin
						send_at(FUNC_CONSUME, 8'($urandom), 1);
					end else if ($urandom_range(0, 3) == 0) begin
						send_byte(sync_byte($urandom_range(0, 2)));
					end else begin
						send_byte(8'($urandom));
					end
				end
				send_at(FUNC_CONSUME, 8'($urandom), 1);
				force_jump = 1'b1;
			end else begin
				send_at(FUNC_CONSUME, 8'($urandom), $urandom_range(0, 3));
			end
			if ($urandom_range(0, 7) == 0) begin
				calm = !calm;
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		rx.valid = 1'b0;
		rx.func = FUNC_BYTE;
		rx.rx_byte = '0;
		rx.now_ms = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		calm = 1'b0;
		steady = 1'b0;
		force_jump = 1'b0;
		gap_cfg = GAP_TIMEOUT_RESET;
		salt_cfg = CHECK_SALT_RESET;
		now = 32'd100;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_at(FUNC_CONSUME, 8'h00, 1);
		send_at(FUNC_BYTE, sync_byte(0), 1);
		// A gap above the timeout makes the next byte start a new frame.
		send_at(FUNC_BYTE, 8'hFF, 10);
		header(8'h00, 8'h00, CHECK_SALT_RESET);
		send_at(FUNC_BYTE, sync_byte(0), 1);
		send_at(FUNC_CONSUME, 8'hFF, 1);
		header(8'h00, 8'h01, 8'h01 ^ CHECK_SALT_RESET);
		send_at(FUNC_BYTE, 8'hFF, 1);
		send_at(FUNC_BYTE, 8'h00, 1);
		send_at(FUNC_BYTE, 8'h80, 1);
		send_at(FUNC_CONSUME, 8'h00, 1);
		header(8'h02, 8'h01, 8'h03 ^ CHECK_SALT_RESET);

		run_phase(250);
		set_config(8'd0, 8'h00);
		run_phase(200);
		set_config(8'd255, 8'hFF);
		steady = 1'b1;
		send_frame(TB_MAX_PIXELS, 1'b0, 7);
		steady = 1'b0;
		run_phase(200);
		set_config(8'($urandom), 8'($urandom));
		now = 32'hFFFF_FF00;
		run_phase(200);
		set_config(8'd1, ~CHECK_SALT_RESET);
		run_phase(200);

		wait_drained();
		if (fails == 0 && pending == 0) begin
			$display("led_frame_parser_tb: PASS");
		end else begin
			$display("led_frame_parser_tb: FAIL");
		end
		$finish;
	end

endmodule
